// ===== rtl/core/rsbp_pkg.sv =====
package rsbp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic        occupied;
    logic [15:0] record_id;
    logic [19:0] plate;
    logic [15:0] brand_id;
    logic [15:0] color_id;
    logic [11:0] model_year;
    logic [15:0] client_id;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic        out_occupied;
    logic [15:0] out_record_id;
    logic [19:0] out_plate;
    logic [15:0] out_brand_id;
    logic [15:0] out_color_id;
    logic [11:0] out_model_year;
    logic [15:0] out_client_id;
    logic        last_out;
  } out_beat_t;

  // One table slot as held in a cell of the chain.
  typedef struct packed {
    logic        occupied;
    logic [15:0] brand_id;
    logic [19:0] plate;
    logic [15:0] record_id;
    logic [15:0] color_id;
    logic [11:0] model_year;
    logic [15:0] client_id;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_SIDE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COMPARE,
    ST_ROTATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load_en;
    logic [IDX_W-1:0] load_slot;
    logic             compare_en;
    logic [IDX_W-1:0] tail;
    logic             rotate_en;
    logic [IDX_W-1:0] last_idx;
    logic             emit_en;
    logic             emit_last;
  } ctrl_t;

endpackage

// ===== rtl/core/rsbp_cell.sv =====
module rsbp_cell (
  input  logic                clk,
  input  rsbp_pkg::cell_op_t  op,
  input  rsbp_pkg::rec_t      load_rec,
  input  rsbp_pkg::rec_t      right_rec,
  input  rsbp_pkg::rec_t      side_rec,
  output rsbp_pkg::rec_t      rec
);
  import rsbp_pkg::*;

  // Slot contents need no reset: only slots loaded for the current table are read.
  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:  rec <= load_rec;
      CELL_SHIFT: rec <= right_rec;
      CELL_SIDE:  rec <= side_rec;
      default:    rec <= rec;
    endcase
  end

endmodule

// ===== rtl/core/rsbp_cmp.sv =====
module rsbp_cmp (
  input  rsbp_pkg::rec_t holder,
  input  rsbp_pkg::rec_t challenger,
  output rsbp_pkg::rec_t lo,
  output rsbp_pkg::rec_t hi
);
  import rsbp_pkg::*;

  logic swap;

  // Both slots must be occupied, and equal keys never swap.
  assign swap = holder.occupied && challenger.occupied &&
                ({holder.brand_id, holder.plate} > {challenger.brand_id, challenger.plate});

  assign lo = swap ? challenger : holder;
  assign hi = swap ? holder : challenger;

endmodule

// ===== rtl/core/rsbp_ctrl.sv =====
module rsbp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            load_valid,
  input  logic            load_last,
  input  logic            out_free,
  output logic            load_stall,
  output rsbp_pkg::ctrl_t ctrl
);
  import rsbp_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] rot;
  logic [IDX_W-1:0] emit_idx;
  logic [IDX_W-1:0] last_idx;
  logic             accept;
  logic             store;
  logic             pass_done;

  assign accept    = (state == ST_LOAD) && load_valid;
  assign store     = accept && (count < CNT_W'(TABLE_DEPTH));
  assign count_inc = count + CNT_W'(store);
  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign pass_done = (tail == '0) || (step == tail - IDX_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:    if (accept && load_last) state_next = ST_COMPARE;
      ST_COMPARE: if (pass_done) state_next = ST_ROTATE;
      ST_ROTATE:  state_next = (rot == last_idx) ? ST_EMIT : ST_COMPARE;
      ST_EMIT:    if (out_free && (emit_idx == last_idx)) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    load_stall      = 1'b1;
    ctrl            = '0;
    ctrl.load_slot  = count[IDX_W-1:0];
    ctrl.tail       = tail;
    ctrl.last_idx   = last_idx;
    ctrl.emit_last  = (emit_idx == last_idx);
    unique case (state)
      ST_LOAD: begin
        load_stall   = 1'b0;
        ctrl.load_en = store;
      end
      ST_COMPARE: ctrl.compare_en = (tail != '0);
      ST_ROTATE:  ctrl.rotate_en  = 1'b1;
      ST_EMIT:    ctrl.emit_en    = out_free;
      default: begin
        load_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      tail     <= '0;
      step     <= '0;
      rot      <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          count <= count_inc;
          if (accept && load_last) begin
            tail <= IDX_W'(count_inc - CNT_W'(1));
            step <= '0;
            rot  <= '0;
          end
        end
        ST_COMPARE: step <= step + IDX_W'(1);
        ST_ROTATE: begin
          step     <= '0;
          tail     <= tail - IDX_W'(1);
          rot      <= rot + IDX_W'(1);
          emit_idx <= '0;
        end
        ST_EMIT: begin
          if (out_free) begin
            emit_idx <= emit_idx + IDX_W'(1);
            if (emit_idx == last_idx) count <= '0;
          end
        end
        default: count <= '0;
      endcase
    end
  end

endmodule

// ===== rtl/core/record_sort_by_brand_plate.sv =====
// Loading takes one beat per cycle while load_stall is low; the sort starts on the
// beat marked last. The sort does one compare per cycle at the head of the cell
// chain, plus one chain rotation at the end of every pass. Emission then gives one
// beat per cycle while the output is not stalled, n beats for n loaded slots.
// Synchronous reset clears the control state and the output valid; slot contents
// are not cleared and are always loaded first.
module record_sort_by_brand_plate (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_stall,
  input  rsbp_pkg::in_beat_t  load_beat,
  output logic                sorted_valid,
  input  logic                sorted_stall,
  output rsbp_pkg::out_beat_t sorted_beat
);
  import rsbp_pkg::*;

  // The table lives in a chain of cells. Cell 0 is the holder of the running
  // exchange-sort pass and cell 1 the challenger. During a pass, cells 1 up to
  // the tail move left by one each cycle, and the larger record of the compare
  // returns to the tail, so that after a pass the challengers are back in order.
  // The whole loaded ring then rotates left by one, which parks the finished
  // holder behind the challengers and brings the next slot to the head. After
  // n rotations every slot is back in its own cell, and emission shifts the
  // chain out through cell 0.

  ctrl_t    ctrl;
  rec_t     cells [TABLE_DEPTH];
  rec_t     load_rec;
  rec_t     lo_rec;
  rec_t     hi_rec;
  logic     out_free;

  assign out_free = !sorted_valid || !sorted_stall;

  rsbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_last  (load_beat.last_in),
    .out_free   (out_free),
    .load_stall (load_stall),
    .ctrl       (ctrl)
  );

  always_comb begin
    load_rec.occupied   = load_beat.occupied;
    load_rec.brand_id   = load_beat.brand_id;
    load_rec.plate      = load_beat.plate;
    load_rec.record_id  = load_beat.record_id;
    load_rec.color_id   = load_beat.color_id;
    load_rec.model_year = load_beat.model_year;
    load_rec.client_id  = load_beat.client_id;
  end

  rsbp_cmp u_cmp (
    .holder     (cells[0]),
    .challenger (cells[1]),
    .lo         (lo_rec),
    .hi         (hi_rec)
  );

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    cell_op_t op;
    rec_t     right_rec;
    rec_t     side_rec;

    if (k == TABLE_DEPTH - 1) begin : g_end
      assign right_rec = cells[k];
    end else begin : g_mid
      assign right_rec = cells[k + 1];
    end

    if (k == 0) begin : g_head
      // The head keeps the smaller record of each compare.
      assign side_rec = lo_rec;
      always_comb begin
        op = CELL_HOLD;
        if (ctrl.load_en && (ctrl.load_slot == '0)) begin
          op = CELL_LOAD;
        end else if (ctrl.compare_en) begin
          op = CELL_SIDE;
        end else if (ctrl.rotate_en && (ctrl.last_idx != '0)) begin
          op = CELL_SHIFT;
        end else if (ctrl.emit_en) begin
          op = CELL_SHIFT;
        end
      end
    end else begin : g_body
      // The tail of a pass takes the larger record; the ring end takes the head.
      assign side_rec = ctrl.rotate_en ? cells[0] : hi_rec;
      always_comb begin
        op = CELL_HOLD;
        if (ctrl.load_en && (ctrl.load_slot == IDX_W'(k))) begin
          op = CELL_LOAD;
        end else if (ctrl.compare_en) begin
          if (ctrl.tail == IDX_W'(k)) begin
            op = CELL_SIDE;
          end else if (ctrl.tail > IDX_W'(k)) begin
            op = CELL_SHIFT;
          end
        end else if (ctrl.rotate_en) begin
          if (ctrl.last_idx == IDX_W'(k)) begin
            op = CELL_SIDE;
          end else if (ctrl.last_idx > IDX_W'(k)) begin
            op = CELL_SHIFT;
          end
        end else if (ctrl.emit_en) begin
          op = CELL_SHIFT;
        end
      end
    end

    rsbp_cell u_cell (
      .clk       (clk),
      .op        (op),
      .load_rec  (load_rec),
      .right_rec (right_rec),
      .side_rec  (side_rec),
      .rec       (cells[k])
    );
  end

  // Output register: an empty slot is given with all fields zero apart from last_out.
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (ctrl.emit_en) begin
      sorted_valid <= 1'b1;
    end else if (!sorted_stall) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_en) begin
      sorted_beat.out_occupied   <= cells[0].occupied;
      sorted_beat.out_record_id  <= cells[0].occupied ? cells[0].record_id : '0;
      sorted_beat.out_plate      <= cells[0].occupied ? cells[0].plate : '0;
      sorted_beat.out_brand_id   <= cells[0].occupied ? cells[0].brand_id : '0;
      sorted_beat.out_color_id   <= cells[0].occupied ? cells[0].color_id : '0;
      sorted_beat.out_model_year <= cells[0].occupied ? cells[0].model_year : '0;
      sorted_beat.out_client_id  <= cells[0].occupied ? cells[0].client_id : '0;
      sorted_beat.last_out       <= ctrl.emit_last;
    end
  end

endmodule
